// ===== sv/pbfa_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the page bitmap first-fit allocator.
// Used by every module of the block; depends on nothing.
package pbfa_pkg;

    localparam int NUM_PAGES  = 4096;
    localparam int WORD_BITS  = 32;
    localparam int WORD_COUNT = NUM_PAGES / WORD_BITS;
    localparam int PAGE_W     = $clog2(NUM_PAGES);
    localparam int CNT_W      = PAGE_W + 1;
    localparam int WADDR_W    = $clog2(WORD_COUNT);
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int PROT_MAX   = 3;

    typedef logic [WORD_BITS-1:0] t_bmword;

    typedef enum logic [1:0] {
        CMD_ALLOC_SEARCH = 2'd0,
        CMD_ALLOC_AT     = 2'd1,
        CMD_FREE         = 2'd2,
        CMD_MARK_AVAIL   = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_ZERO_LEN = 3'd1,
        ST_BAD_PROT = 3'd2,
        ST_NO_RUN   = 3'd3,
        ST_PAST_END = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_MARK
    } t_state;

    typedef struct packed {
        t_cmd              command;
        logic [11:0]       base_page;
        logic [12:0]       page_count;
        logic [2:0]        prot;
    } t_in_word;

    typedef struct packed {
        t_status           status;
        logic [11:0]       result_page;
    } t_out_word;

    typedef struct packed {
        logic [WADDR_W-1:0] rd_addr;
        logic               wr_en;
        logic [WADDR_W-1:0] wr_addr;
        t_bmword            wr_data;
    } t_ram_req;

    typedef struct packed {
        t_bmword            used;
        logic [CNT_W-1:0]   carry;
        logic [CNT_W-1:0]   count;
        logic [BIT_W-1:0]   limit_bit;
        logic               apply_limit;
    } t_scan_req;

    typedef struct packed {
        logic               hit;
        logic [BIT_W-1:0]   hit_bit;
        logic [CNT_W-1:0]   run_out;
    } t_scan_rsp;

endpackage

// ===== sv/pbfa_bitmap_ram.sv =====
`timescale 1ns / 1ps
// Page used/free bitmap: one word per address, registered read, one write port.
// Depends on pbfa_pkg; unwritten words read as all used.
module pbfa_bitmap_ram (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pbfa_pkg::t_ram_req i_req,
    output pbfa_pkg::t_bmword  o_rd_data
);
    import pbfa_pkg::*;

    t_bmword                r_mem [WORD_COUNT];
    logic [WORD_COUNT-1:0]  r_written;
    t_bmword                r_rd_word;
    logic                   r_rd_written;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        r_rd_word <= r_mem[i_req.rd_addr];
    end

    // a word never written reads as all ones through r_written: every page used
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written    <= '0;
            r_rd_written <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_written[i_req.wr_addr] <= 1'b1;
            end
            r_rd_written <= r_written[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_written ? r_rd_word : '1;

endmodule

// ===== sv/pbfa_word_scan.sv =====
`timescale 1ns / 1ps
// Scan unit: finds the first page in one bitmap word that completes a
// free run of the requested length, and the free run carried to the next word.
// Depends on pbfa_pkg.
module pbfa_word_scan (
    input  pbfa_pkg::t_scan_req i_req,
    output pbfa_pkg::t_scan_rsp o_rsp
);
    import pbfa_pkg::*;

    t_bmword            used_eff;
    t_bmword            free_v;
    t_bmword            pre_free;
    t_bmword            win;
    t_bmword            hit_vec;
    t_bmword            grp [BIT_W+1];
    logic [CNT_W:0]     need;
    logic               short_run;
    logic [BIT_W-1:0]   first_bit;
    logic [CNT_W-1:0]   tail_free;

    always_comb begin
        // pages above the search limit count as used
        for (int b = 0; b < WORD_BITS; b++) begin
            used_eff[b] = i_req.used[b] |
                          (i_req.apply_limit && (BIT_W'(b) > i_req.limit_bit));
        end
        free_v = ~used_eff;

        pre_free[0] = free_v[0];
        for (int b = 1; b < WORD_BITS; b++) begin
            pre_free[b] = pre_free[b-1] & free_v[b];
        end

        // grp[k][b]: at least 2**k free pages ending at bit b, inside the word
        grp[0] = free_v;
        for (int k = 1; k <= BIT_W; k++) begin
            grp[k] = grp[k-1] & (grp[k-1] << (1 << (k-1)));
        end

        // compose a window of exactly page_count pages from the binary digits
        win = '1;
        for (int k = 0; k <= BIT_W; k++) begin
            if (i_req.count[k]) begin
                win = grp[k] & (win << (1 << k));
            end
        end
        short_run = (i_req.count <= CNT_W'(WORD_BITS));
        if (!short_run) begin
            win = '0;
        end

        // runs that reach back into earlier words
        need = {1'b0, i_req.count} - {1'b0, i_req.carry};
        for (int b = 0; b < WORD_BITS; b++) begin
            hit_vec[b] = win[b] | (pre_free[b] && (need <= (CNT_W+1)'(b + 1)));
        end

        first_bit = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (hit_vec[b]) begin
                first_bit = BIT_W'(b);
            end
        end

        tail_free = CNT_W'(WORD_BITS);
        for (int b = 0; b < WORD_BITS; b++) begin
            if (used_eff[b]) begin
                tail_free = CNT_W'(WORD_BITS - 1 - b);
            end
        end

        o_rsp.hit     = |hit_vec;
        o_rsp.hit_bit = first_bit;
        o_rsp.run_out = (&free_v) ? (i_req.carry + CNT_W'(WORD_BITS)) : tail_free;
    end

endmodule

// ===== sv/pbfa_seq.sv =====
`timescale 1ns / 1ps
// Command sequencer: checks, word-by-word first-fit search, run marking and
// the result register. Depends on pbfa_pkg; drives pbfa_bitmap_ram and pbfa_word_scan.
module pbfa_seq (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  pbfa_pkg::t_in_word         i_in_word,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output pbfa_pkg::t_out_word        o_out_word,
    input  logic                       i_cfg_wr,
    input  logic [pbfa_pkg::PAGE_W-1:0] i_cfg_data,
    output pbfa_pkg::t_ram_req         o_ram_req,
    input  pbfa_pkg::t_bmword          i_rd_data,
    output pbfa_pkg::t_scan_req        o_scan_req,
    input  pbfa_pkg::t_scan_rsp        i_scan_rsp
);
    import pbfa_pkg::*;

    t_state             r_state, n_state;
    logic [PAGE_W-1:0]  r_search_limit;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [PAGE_W-1:0]  r_start, n_start;
    logic [PAGE_W-1:0]  r_end, n_end;
    logic               r_set_used, n_set_used;
    logic               r_is_alloc, n_is_alloc;
    logic [WADDR_W-1:0] r_next, n_next;
    logic [WADDR_W-1:0] r_q_addr;
    logic [CNT_W-1:0]   r_run, n_run;
    logic               r_out_valid, n_out_valid;
    t_out_word          r_out_word, n_out_word;

    logic               in_accept;
    logic               is_alloc_cmd;
    logic [PAGE_W-1:0]  hit_page;
    logic [PAGE_W-1:0]  hit_start;
    logic [WADDR_W-1:0] limit_word;
    t_bmword            mark_mask;

    assign o_in_stall   = (r_state != S_IDLE) || (r_out_valid && i_out_stall);
    assign in_accept    = i_in_valid && !o_in_stall;
    assign is_alloc_cmd = (i_in_word.command == CMD_ALLOC_SEARCH) ||
                          (i_in_word.command == CMD_ALLOC_AT);
    assign limit_word   = r_search_limit[PAGE_W-1:BIT_W];
    assign hit_page     = {r_q_addr, i_scan_rsp.hit_bit};
    assign hit_start    = PAGE_W'({1'b0, hit_page} + CNT_W'(1) - r_count);

    assign o_scan_req.used        = i_rd_data;
    assign o_scan_req.carry       = r_run;
    assign o_scan_req.count       = r_count;
    assign o_scan_req.limit_bit   = r_search_limit[BIT_W-1:0];
    assign o_scan_req.apply_limit = (r_q_addr == limit_word);

    // bits of the current word that fall inside the run
    always_comb begin
        for (int b = 0; b < WORD_BITS; b++) begin
            mark_mask[b] = ((r_q_addr != r_start[PAGE_W-1:BIT_W]) ||
                            (BIT_W'(b) >= r_start[BIT_W-1:0])) &&
                           ((r_q_addr != r_end[PAGE_W-1:BIT_W]) ||
                            (BIT_W'(b) <= r_end[BIT_W-1:0]));
        end
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_start     = r_start;
        n_end       = r_end;
        n_set_used  = r_set_used;
        n_is_alloc  = r_is_alloc;
        n_run       = r_run;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_word  = r_out_word;

        o_ram_req.rd_addr = r_next;
        o_ram_req.wr_en   = 1'b0;
        o_ram_req.wr_addr = r_q_addr;
        o_ram_req.wr_data = r_set_used ? (i_rd_data | mark_mask) : (i_rd_data & ~mark_mask);

        unique case (r_state)
            S_IDLE: begin
                o_ram_req.rd_addr = (i_in_word.command == CMD_ALLOC_SEARCH) ?
                                    '0 : i_in_word.base_page[PAGE_W-1:BIT_W];
                if (in_accept) begin
                    n_count    = i_in_word.page_count;
                    n_start    = i_in_word.base_page;
                    n_end      = PAGE_W'(CNT_W'(i_in_word.base_page) +
                                         i_in_word.page_count - CNT_W'(1));
                    n_set_used = is_alloc_cmd;
                    n_is_alloc = is_alloc_cmd;
                    n_run      = '0;
                    n_out_word.result_page = '0;
                    priority if (i_in_word.page_count == '0) begin
                        n_out_valid       = 1'b1;
                        n_out_word.status = ST_ZERO_LEN;
                    end else if (is_alloc_cmd && (i_in_word.prot > 3'(PROT_MAX))) begin
                        n_out_valid       = 1'b1;
                        n_out_word.status = ST_BAD_PROT;
                    end else if (i_in_word.command == CMD_ALLOC_SEARCH) begin
                        n_state = S_SEARCH;
                    end else if ((CNT_W+1)'(i_in_word.base_page) +
                                 (CNT_W+1)'(i_in_word.page_count) >
                                 (CNT_W+1)'(NUM_PAGES)) begin
                        n_out_valid       = 1'b1;
                        n_out_word.status = ST_PAST_END;
                    end else begin
                        n_state = S_MARK;
                    end
                end
            end
            S_SEARCH: begin
                priority if (i_scan_rsp.hit) begin
                    // restart the read stream at the first word of the run
                    n_start           = hit_start;
                    n_end             = hit_page;
                    o_ram_req.rd_addr = hit_start[PAGE_W-1:BIT_W];
                    n_state           = S_MARK;
                end else if (r_q_addr == limit_word) begin
                    n_out_valid            = 1'b1;
                    n_out_word.status      = ST_NO_RUN;
                    n_out_word.result_page = '0;
                    n_state                = S_IDLE;
                end else begin
                    n_run = i_scan_rsp.run_out;
                end
            end
            S_MARK: begin
                o_ram_req.wr_en = 1'b1;
                if (r_q_addr == r_end[PAGE_W-1:BIT_W]) begin
                    n_out_valid            = 1'b1;
                    n_out_word.status      = ST_OK;
                    n_out_word.result_page = r_is_alloc ? r_start : '0;
                    n_state                = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_next = o_ram_req.rd_addr + WADDR_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_out_valid    <= 1'b0;
            r_search_limit <= '1;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr) begin
                r_search_limit <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_count    <= n_count;
        r_start    <= n_start;
        r_end      <= n_end;
        r_set_used <= n_set_used;
        r_is_alloc <= n_is_alloc;
        r_run      <= n_run;
        r_next     <= n_next;
        r_q_addr   <= o_ram_req.rd_addr;
        r_out_word <= n_out_word;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    a_mark_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MARK) |-> ((r_q_addr >= r_start[PAGE_W-1:BIT_W]) &&
                                 (r_q_addr <= r_end[PAGE_W-1:BIT_W])))
        else $error("marking a word outside the run");

    a_mark_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MARK) |-> (r_start <= r_end))
        else $error("run start beyond run end");

    a_search_carry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH) |-> (r_run < r_count))
        else $error("carried free run already long enough");

    a_search_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH) |-> (r_q_addr <= limit_word))
        else $error("search past the limit word");

    a_done_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state != S_IDLE) && (n_state == S_IDLE)) |=> o_out_valid)
        else $error("command finished without a result word");

endmodule

// ===== sv/page_bitmap_first_fit_allocator.sv =====
`timescale 1ns / 1ps
// Bitmap first-fit page allocator over 4096 pages, every page used after reset.
// Zero length, bad protection and run past end answer in the accept cycle; the
// result word is registered and shows in the following cycle. Allocate-at, free
// and mark-available read the first word of the run, then mark each bitmap word
// the run touches in turn. Allocate-by-search reads one 32-page word per cycle
// from page 0 through the word holding the first fitting run (at most up to
// search_limit), then goes back and marks the run one word per cycle. The bitmap
// has a single read port, and the search runs through the word scan unit. One
// command is in flight at a time, and a new command is held off while a finished
// result word waits under stall in the output register. The bitmap needs no
// clearing pass after reset. search_limit is written through the cfg channel,
// which is always ready.
module page_bitmap_first_fit_allocator (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  pbfa_pkg::t_in_word          i_in_word,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output pbfa_pkg::t_out_word         o_out_word,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [pbfa_pkg::PAGE_W-1:0] i_cfg_data
);
    import pbfa_pkg::*;

    t_ram_req  ram_req;
    t_bmword   rd_data;
    t_scan_req scan_req;
    t_scan_rsp scan_rsp;

    assign o_cfg_ready = 1'b1;

    pbfa_bitmap_ram u_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (ram_req),
        .o_rd_data (rd_data)
    );

    pbfa_word_scan u_scan (
        .i_req (scan_req),
        .o_rsp (scan_rsp)
    );

    pbfa_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_wr    (i_cfg_valid && o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_ram_req   (ram_req),
        .i_rd_data   (rd_data),
        .o_scan_req  (scan_req),
        .i_scan_rsp  (scan_rsp)
    );

endmodule

// ===== verif/page_bitmap_first_fit_allocator_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for page_bitmap_first_fit_allocator: directed and random commands.
// Depends on pbfa_pkg and the allocator RTL; keeps its own page bitmap to predict each word.
module page_bitmap_first_fit_allocator_tb;
    import pbfa_pkg::*;

    localparam int CYCLE_LIMIT   = 2_500_000;
    localparam int SETTLE_CYCLES = 300;
    localparam int IDLE_PCT      = 36;

    typedef struct {
        int unsigned start_page;
        int unsigned pages;
    } t_run;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    t_in_word            i_in_word;
    logic                o_out_valid;
    logic                i_out_stall;
    t_out_word           o_out_word;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [PAGE_W-1:0]   i_cfg_data;

    // Predicted allocator state
    bit [NUM_PAGES-1:0]  page_used;
    logic [PAGE_W-1:0]   scan_limit;
    t_out_word           pending_answers[$];
    t_run                live_runs[$];

    bit                  calm;
    int unsigned         mismatches;
    int unsigned         words_sent;
    int unsigned         words_checked;
    int unsigned         limits_used;

    page_bitmap_first_fit_allocator i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic void fill_run(int base, int count, bit used);
        for (int i = 0; i < count; i++) begin
            page_used[base + i] = used;
        end
    endfunction

    // Apply one command to the predicted bitmap and return the word it should produce
    function automatic t_out_word apply_page_command(t_in_word w);
        t_out_word ans;
        int        run;
        int        hit;
        ans.status      = ST_OK;
        ans.result_page = '0;
        run = 0;
        hit = -1;
        if (w.page_count == 0) begin
            ans.status = ST_ZERO_LEN;
        end else if ((w.command == CMD_ALLOC_SEARCH || w.command == CMD_ALLOC_AT)
                     && w.prot > PROT_MAX) begin
            ans.status = ST_BAD_PROT;
        end else if (w.command == CMD_ALLOC_SEARCH) begin
            // first fit: the run ends at the first page where enough free pages have piled up
            for (int i = 0; i <= int'(scan_limit) && hit < 0; i++) begin
                if (page_used[i]) begin
                    run = 0;
                end else begin
                    run++;
                    if (run == int'(w.page_count)) hit = i + 1 - run;
                end
            end
            if (hit < 0) begin
                ans.status = ST_NO_RUN;
            end else begin
                fill_run(hit, w.page_count, 1'b1);
                ans.result_page = hit[PAGE_W-1:0];
            end
        end else if (int'(w.base_page) + int'(w.page_count) > NUM_PAGES) begin
            ans.status = ST_PAST_END;
        end else if (w.command == CMD_ALLOC_AT) begin
            fill_run(w.base_page, w.page_count, 1'b1);
            ans.result_page = w.base_page;
        end else begin
            fill_run(w.base_page, w.page_count, 1'b0);
        end
        return ans;
    endfunction

    function automatic t_in_word make_command(t_cmd c, int base, int count, int prot);
        t_in_word w;
        w.command    = c;
        w.base_page  = base[PAGE_W-1:0];
        w.page_count = count[CNT_W-1:0];
        w.prot       = prot[2:0];
        return w;
    endfunction

    // Mostly short runs, now and then one up to the whole bitmap
    function automatic int random_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return $urandom_range(1, 8);
        if (roll < 90) return $urandom_range(9, 64);
        if (roll < 98) return $urandom_range(65, 512);
        return $urandom_range(513, NUM_PAGES);
    endfunction

    function automatic t_in_word random_command();
        t_in_word                     w;
        logic [31:0]                  raw;
        int                           pick;
        int                           len;
        int                           idx;
        t_run                         r;
        pick = $urandom_range(0, 99);
        len  = random_len();
        w = make_command(CMD_ALLOC_SEARCH, 0, len, $urandom_range(0, PROT_MAX));
        if (pick < 12) begin
            // noise: every field over its full width
            raw = $urandom();
            w   = raw[$bits(t_in_word)-1:0];
        end else if (pick < 45) begin
            w.base_page = PAGE_W'($urandom());
        end else if (pick < 57) begin
            w = make_command(CMD_ALLOC_AT, $urandom_range(0, NUM_PAGES - len), len,
                             $urandom_range(0, PROT_MAX));
        end else if (pick < 85) begin
            // mostly free something handed out earlier, where there is one
            if (live_runs.size() != 0 && $urandom_range(0, 9) < 8) begin
                idx = $urandom_range(0, live_runs.size() - 1);
                r   = live_runs[idx];
                live_runs.delete(idx);
                w = make_command(CMD_FREE, r.start_page, r.pages, $urandom_range(0, 7));
            end else begin
                w = make_command(CMD_FREE, $urandom_range(0, NUM_PAGES - len), len,
                                 $urandom_range(0, 7));
            end
        end else begin
            w = make_command(CMD_MARK_AVAIL, $urandom_range(0, NUM_PAGES - len), len,
                             $urandom_range(0, 7));
        end
        return w;
    endfunction

    task automatic send_command(t_in_word w);
        t_out_word ans;
        if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < IDLE_PCT);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (o_in_stall);
        ans = apply_page_command(w);
        pending_answers.push_back(ans);
        words_sent++;
        if (ans.status == ST_OK && (w.command == CMD_ALLOC_SEARCH || w.command == CMD_ALLOC_AT))
            live_runs.push_back('{start_page: ans.result_page, pages: w.page_count});
    endtask

    // Drop valid and wait for every outstanding word
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_answers.size() != 0);
    endtask

    task automatic write_search_limit(logic [PAGE_W-1:0] lim);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= lim;
        do @(posedge i_clk); while (!o_cfg_ready);
        scan_limit = lim;
        limits_used++;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic test_reset_state();
        send_command(make_command(CMD_ALLOC_SEARCH, 0, 1, 0));
        send_command(make_command(CMD_ALLOC_SEARCH, 0, NUM_PAGES, 0));
    endtask

    task automatic test_rejections();
        send_command(make_command(CMD_ALLOC_SEARCH, 0, 0, 7));
        send_command(make_command(CMD_ALLOC_AT, 5, 0, 0));
        send_command(make_command(CMD_FREE, 5, 0, 0));
        send_command(make_command(CMD_MARK_AVAIL, 5, 0, 0));
        send_command(make_command(CMD_ALLOC_SEARCH, 0, 1, 4));
        // protection is judged before the extent
        send_command(make_command(CMD_ALLOC_AT, NUM_PAGES - 1, 2, 7));
        send_command(make_command(CMD_ALLOC_AT, NUM_PAGES - 1, 2, 3));
        send_command(make_command(CMD_FREE, 1, NUM_PAGES, 0));
        send_command(make_command(CMD_MARK_AVAIL, NUM_PAGES - 1, 8191, 0));
    endtask

    task automatic test_whole_bitmap();
        send_command(make_command(CMD_MARK_AVAIL, 0, NUM_PAGES, 7));
        send_command(make_command(CMD_ALLOC_SEARCH, 0, NUM_PAGES, PROT_MAX));
        send_command(make_command(CMD_FREE, 0, NUM_PAGES, 5));
        send_command(make_command(CMD_ALLOC_AT, NUM_PAGES - 1, 1, 0));
        send_command(make_command(CMD_ALLOC_SEARCH, 0, 8191, 0));
        send_command(make_command(CMD_ALLOC_AT, 100, 50, 1));
        // already used pages are marked again without complaint
        send_command(make_command(CMD_ALLOC_AT, 100, 10, 2));
        send_command(make_command(CMD_ALLOC_SEARCH, 0, 200, 0));
    endtask

    task automatic test_search_limit();
        wait_idle();
        write_search_limit('0);
        send_command(make_command(CMD_ALLOC_SEARCH, 0, 1, 0));
        send_command(make_command(CMD_ALLOC_SEARCH, 0, 1, 0));
        wait_idle();
        write_search_limit(PAGE_W'(31));
        send_command(make_command(CMD_ALLOC_SEARCH, 0, 31, 0));
        send_command(make_command(CMD_ALLOC_SEARCH, 0, 1, 0));
        send_command(make_command(CMD_FREE, 0, NUM_PAGES, 0));
    endtask

    task automatic test_random_mix(int count, logic [PAGE_W-1:0] lim, bit quiet);
        wait_idle();
        write_search_limit(lim);
        calm = quiet;
        repeat (count) send_command(random_command());
        calm = 1'b0;
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_word   <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= '0;
        calm          = 1'b0;
        mismatches    = 0;
        words_sent    = 0;
        words_checked = 0;
        limits_used   = 0;
        page_used     = '1;
        scan_limit    = PAGE_W'(NUM_PAGES - 1);
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_search_limit(PAGE_W'(NUM_PAGES - 1));

        test_reset_state();
        test_rejections();
        test_whole_bitmap();
        test_search_limit();
        test_random_mix(450, PAGE_W'(NUM_PAGES - 1), 1'b0);
        test_random_mix(120, '0, 1'b0);
        test_random_mix(300, PAGE_W'($urandom_range(1, NUM_PAGES - 2)), 1'b0);
        test_random_mix(350, PAGE_W'(NUM_PAGES - 1), 1'b1);
        test_random_mix(150, PAGE_W'(31), 1'b0);
        test_random_mix(200, PAGE_W'(2047), 1'b0);

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_answers.size() != 0) mismatches++;
        $display("ran %0d commands under %0d search limit writes", words_sent, limits_used);
        $display("checked %0d result words, %0d wrong", words_checked, mismatches);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Receiver back-pressure
    initial begin
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            i_out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    initial begin : result_check
        t_out_word want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                words_checked++;
                if (pending_answers.size() == 0) begin
                    mismatches++;
                    $error("unexpected result word: status %0d, result_page %0d",
                           o_out_word.status, o_out_word.result_page);
                end else begin
                    want = pending_answers.pop_front();
                    if (o_out_word.status !== want.status) begin
                        mismatches++;
                        $error("status: expected %0d, got %0d", want.status, o_out_word.status);
                    end
                    if (o_out_word.result_page !== want.result_page) begin
                        mismatches++;
                        $error("result_page: expected %0d, got %0d",
                               want.result_page, o_out_word.result_page);
                    end
                end
            end
        end
    end

    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("timed out with %0d result words outstanding", pending_answers.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== page_bitmap_first_fit_allocator.f =====
sv/pbfa_pkg.sv
sv/pbfa_bitmap_ram.sv
sv/pbfa_word_scan.sv
sv/pbfa_seq.sv
sv/page_bitmap_first_fit_allocator.sv
verif/page_bitmap_first_fit_allocator_tb.sv
